>>> design/sobel_edge_threshold_defines.svh
// Assertion macros used by the Sobel edge threshold top level.
`ifndef SOBEL_EDGE_THRESHOLD_DEFINES_SVH
`define SOBEL_EDGE_THRESHOLD_DEFINES_SVH

// Same-cycle implication, sampled on aclk, quiet during reset
`define SEDGE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, quiet during reset
`define SEDGE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sedge_pkg.sv
// Shared constants, types and codes for the Sobel edge threshold block.
package sedge_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Register widths
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int THR_W    = 8;
    localparam int CFG_W    = 13;
    localparam int CFG_IW   = 2;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);
    localparam logic [THR_W-1:0]    THR_RST    = THR_W'(128);

    // Clamp bounds for the dimensions in use
    localparam logic [WIDTH_W-1:0]  DIM_MIN_W = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  DIM_MAX_W = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] DIM_MIN_H = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] DIM_MAX_H = HEIGHT_W'(MAX_HEIGHT);

    // Pixel and arithmetic widths
    localparam int PIX_W    = 8;
    localparam int SUM_W    = 10;
    localparam int PROD_W   = 20;
    localparam int ABS_W    = 10;
    localparam int GRAD_W   = 11;
    localparam int SQ_W     = 20;
    localparam int MAG_W    = 21;
    localparam int LIM_SQ_W = 17;

    // Divide by three as multiply by reciprocal: exact for sums up to 765
    localparam logic [SUM_W-1:0] DIV3_MUL   = SUM_W'(683);
    localparam int               DIV3_SHIFT = 11;

    // Output levels
    localparam logic [PIX_W-1:0] EDGE_ON  = PIX_W'(255);
    localparam logic [PIX_W-1:0] EDGE_OFF = PIX_W'(0);

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } cfg_index_e;

    // Per-pixel control travelling alongside the pixel
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [COL_W-1:0] center_col;
        logic [ROW_W-1:0] center_row;
    } pix_ctl_t;

    // One result word
    typedef struct packed {
        logic             last;
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic [PIX_W-1:0] level;
    } res_t;

endpackage

>>> design/sedge_linemem.sv
// Two line stores (row above and middle row) with registered reads.
module sedge_linemem (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [sedge_pkg::COL_W-1:0] rd_addr,
    input  logic                       wr_en,
    input  logic [sedge_pkg::COL_W-1:0] wr_addr,
    input  logic [sedge_pkg::PIX_W-1:0] wr_cur,
    output logic [sedge_pkg::PIX_W-1:0] top_rd_data,
    output logic [sedge_pkg::PIX_W-1:0] mid_rd_data
);

    logic [sedge_pkg::PIX_W-1:0] top_mem [sedge_pkg::MAX_WIDTH];
    logic [sedge_pkg::PIX_W-1:0] mid_mem [sedge_pkg::MAX_WIDTH];
    logic [sedge_pkg::PIX_W-1:0] top_rd_reg;
    logic [sedge_pkg::PIX_W-1:0] mid_rd_reg;

    // Read one column of both stores
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            top_rd_reg <= top_mem[rd_addr];
            mid_rd_reg <= mid_mem[rd_addr];
        end
    end

    // Roll the column up: middle moves to top, current into middle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            top_mem[wr_addr] <= mid_rd_reg;
            mid_mem[wr_addr] <= wr_cur;
        end
    end

    assign top_rd_data = top_rd_reg;
    assign mid_rd_data = mid_rd_reg;

endmodule

>>> design/sedge_grad.sv
// Window taps, Sobel gradients and magnitude threshold, three stages.
module sedge_grad (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  sedge_pkg::pix_ctl_t           in_ctl,
    input  logic [sedge_pkg::PIX_W-1:0]    in_cur,
    input  logic [sedge_pkg::PIX_W-1:0]    in_top,
    input  logic [sedge_pkg::PIX_W-1:0]    in_mid,
    input  logic [sedge_pkg::LIM_SQ_W-1:0] lim_sq,
    output logic                          done,
    output logic                          push,
    output sedge_pkg::res_t               push_data
);

    // taps: 0,1 top row; 2,3 middle; 4,5 bottom; older first
    logic [sedge_pkg::PIX_W-1:0] taps_reg [6];

    logic [sedge_pkg::SUM_W-1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [sedge_pkg::GRAD_W-1:0] gx, gy, gx_abs, gy_abs;

    logic                         s2_valid_reg;
    sedge_pkg::pix_ctl_t          s2_ctl_reg;
    logic [sedge_pkg::ABS_W-1:0]  ax_reg, ay_reg;

    logic                         s3_valid_reg;
    sedge_pkg::pix_ctl_t          s3_ctl_reg;
    logic [sedge_pkg::SQ_W-1:0]   sqx_reg, sqy_reg;
    logic [sedge_pkg::MAG_W-1:0]  mag2;

    // Shift the window by one column per pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                taps_reg[i] <= '0;
            end
        end else if (in_valid) begin
            taps_reg[0] <= taps_reg[1];
            taps_reg[1] <= in_top;
            taps_reg[2] <= taps_reg[3];
            taps_reg[3] <= in_mid;
            taps_reg[4] <= taps_reg[5];
            taps_reg[5] <= in_cur;
        end
    end

    // Kernel sums and absolute gradients
    always_comb begin
        gx_pos = {2'b00, in_top} + {1'b0, in_mid, 1'b0} + {2'b00, in_cur};
        gx_neg = {2'b00, taps_reg[0]} + {1'b0, taps_reg[2], 1'b0} + {2'b00, taps_reg[4]};
        gy_pos = {2'b00, taps_reg[4]} + {1'b0, taps_reg[5], 1'b0} + {2'b00, in_cur};
        gy_neg = {2'b00, taps_reg[0]} + {1'b0, taps_reg[1], 1'b0} + {2'b00, in_top};
        gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
        gx_abs = gx[sedge_pkg::GRAD_W-1] ? -gx : gx;
        gy_abs = gy[sedge_pkg::GRAD_W-1] ? -gy : gy;
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= in_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payloads: gradients, then squares
    always_ff @(posedge aclk) begin
        s2_ctl_reg <= in_ctl;
        ax_reg     <= gx_abs[sedge_pkg::ABS_W-1:0];
        ay_reg     <= gy_abs[sedge_pkg::ABS_W-1:0];
        s3_ctl_reg <= s2_ctl_reg;
        sqx_reg    <= ax_reg * ax_reg;
        sqy_reg    <= ay_reg * ay_reg;
    end

    // Magnitude compare against (threshold+1) squared
    assign mag2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_comb begin
        push_data.last       = s3_ctl_reg.last;
        push_data.center_row = s3_ctl_reg.center_row;
        push_data.center_col = s3_ctl_reg.center_col;
        push_data.level      = (mag2 >= sedge_pkg::MAG_W'(lim_sq)) ?
                               sedge_pkg::EDGE_ON : sedge_pkg::EDGE_OFF;
    end

    assign done = s3_valid_reg;
    assign push = s3_valid_reg & s3_ctl_reg.emit;

endmodule

>>> design/sedge_ofifo.sv
// Output queue of result words between the pipeline and the master port.
module sedge_ofifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  sedge_pkg::res_t               push_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sedge_pkg::res_t               out_data,
    output logic [sedge_pkg::FIFO_CW-1:0] count
);

    sedge_pkg::res_t                 q_mem [sedge_pkg::FIFO_DEPTH];
    logic [sedge_pkg::FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [sedge_pkg::FIFO_CW-1:0]   count_reg;
    logic                            pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid & out_ready;
    assign out_data  = q_mem[rd_ptr_reg];
    assign count     = count_reg;

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> design/sobel_edge_threshold.sv
// Top level of the streaming Sobel 3x3 edge detector with magnitude threshold.
//
// Takes one RGB pixel per clock in raster order while s_tready is high, returns one word
// per interior pixel: 255 where floor(sqrt(gx^2+gy^2)) exceeds edge_threshold, 0
// otherwise, with the window centre position and a last flag on the final interior pixel
// of a frame. Throughput is one pixel per cycle while s_tready is high, set by the single
// read and single write per cycle on each of the two line stores. A result word is
// registered in the memory, gradient and square stages and the output queue before it
// appears on m_tvalid; the eight-word output queue absorbs stalls on the master side, and
// s_tready drops once the words held in that queue plus the pixels still in the three
// pipeline stages reach eight. The line stores need no clearing after reset. Registers are
// to be written through cfg_wr_* only while no pixel is in flight; this is not enforced.
module sobel_edge_threshold (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [sedge_pkg::CFG_IW-1:0]    cfg_wr_index,
    input  logic [sedge_pkg::CFG_W-1:0]     cfg_wr_data,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // edge_level[7:0], center_column[17:8],
                                                       // center_row[29:18], zero[31:30]
    output logic                            m_tlast    // frame_last
);

    `include "sobel_edge_threshold_defines.svh"

    // Configuration registers
    logic [sedge_pkg::WIDTH_W-1:0]   width_reg;
    logic [sedge_pkg::HEIGHT_W-1:0]  height_reg;
    logic [sedge_pkg::THR_W-1:0]     thr_reg;
    logic [sedge_pkg::LIM_SQ_W-1:0]  lim_sq_reg;
    logic [sedge_pkg::THR_W:0]       thr_plus;
    logic [2*sedge_pkg::THR_W+1:0]   lim_sq_next;

    // Position counters
    logic [sedge_pkg::COL_W-1:0]     col_reg, col_next;
    logic [sedge_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [sedge_pkg::WIDTH_W-1:0]   width_use, col_inc;
    logic [sedge_pkg::HEIGHT_W-1:0]  height_use, row_inc;
    logic                            col_wrap, row_wrap;

    // Intake
    logic                            s_accept;
    logic [sedge_pkg::SUM_W-1:0]     rgb_sum;
    logic [sedge_pkg::PROD_W-1:0]    rgb_prod;
    logic [sedge_pkg::PIX_W-1:0]     intensity;
    sedge_pkg::pix_ctl_t             ctl;

    // Memory stage
    logic                            s1_valid_reg;
    sedge_pkg::pix_ctl_t             s1_ctl_reg;
    logic [sedge_pkg::PIX_W-1:0]     s1_cur_reg;
    logic [sedge_pkg::COL_W-1:0]     s1_addr_reg;
    logic [sedge_pkg::PIX_W-1:0]     top_data, mid_data;

    // Flow control
    logic [1:0]                      inflight_reg, inflight_next;
    logic                            grad_done, grad_push;
    sedge_pkg::res_t                 grad_data, out_data;
    logic [sedge_pkg::FIFO_CW-1:0]   fifo_count;
    logic [sedge_pkg::FIFO_CW-1:0]   occupancy;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= sedge_pkg::WIDTH_RST;
            height_reg <= sedge_pkg::HEIGHT_RST;
            thr_reg    <= sedge_pkg::THR_RST;
        end else if (cfg_wr_en) begin
            unique case (sedge_pkg::cfg_index_e'(cfg_wr_index))
                sedge_pkg::CFG_IMAGE_WIDTH:
                    width_reg <= cfg_wr_data[sedge_pkg::WIDTH_W-1:0];
                sedge_pkg::CFG_IMAGE_HEIGHT:
                    height_reg <= cfg_wr_data[sedge_pkg::HEIGHT_W-1:0];
                sedge_pkg::CFG_EDGE_THRESHOLD:
                    thr_reg <= cfg_wr_data[sedge_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // (threshold+1)^2, kept registered
    assign thr_plus    = {1'b0, thr_reg} + 1'b1;
    assign lim_sq_next = thr_plus * thr_plus;

    always_ff @(posedge aclk) begin
        lim_sq_reg <= lim_sq_next[sedge_pkg::LIM_SQ_W-1:0];
    end

    // Dimensions held within their legal ranges
    always_comb begin
        if (width_reg < sedge_pkg::DIM_MIN_W) begin
            width_use = sedge_pkg::DIM_MIN_W;
        end else if (width_reg > sedge_pkg::DIM_MAX_W) begin
            width_use = sedge_pkg::DIM_MAX_W;
        end else begin
            width_use = width_reg;
        end
        if (height_reg < sedge_pkg::DIM_MIN_H) begin
            height_use = sedge_pkg::DIM_MIN_H;
        end else if (height_reg > sedge_pkg::DIM_MAX_H) begin
            height_use = sedge_pkg::DIM_MAX_H;
        end else begin
            height_use = height_reg;
        end
    end

    // Handshake and credit check
    assign occupancy = fifo_count + sedge_pkg::FIFO_CW'(inflight_reg);
    assign s_tready  = (occupancy < sedge_pkg::FIFO_CW'(sedge_pkg::FIFO_DEPTH));
    assign s_accept  = s_tvalid & s_tready;

    // Raster counters
    always_comb begin
        col_inc  = sedge_pkg::WIDTH_W'(col_reg) + 1'b1;
        row_inc  = sedge_pkg::HEIGHT_W'(row_reg) + 1'b1;
        col_wrap = (col_inc >= width_use);
        row_wrap = (row_inc >= height_use);
        col_next = col_inc[sedge_pkg::COL_W-1:0];
        row_next = row_reg;
        if (col_wrap) begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_inc[sedge_pkg::ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Intensity (r+g+b)/3 and per-pixel control
    always_comb begin
        rgb_sum   = sedge_pkg::SUM_W'(s_tdata[7:0]) + sedge_pkg::SUM_W'(s_tdata[15:8])
                  + sedge_pkg::SUM_W'(s_tdata[23:16]);
        rgb_prod  = rgb_sum * sedge_pkg::DIV3_MUL;
        intensity = rgb_prod[sedge_pkg::DIV3_SHIFT +: sedge_pkg::PIX_W];

        ctl.emit       = (row_reg >= sedge_pkg::ROW_W'(2)) && (col_reg >= sedge_pkg::COL_W'(2))
                      && (sedge_pkg::HEIGHT_W'(row_reg) < height_use)
                      && (sedge_pkg::WIDTH_W'(col_reg) < width_use);
        ctl.last       = (sedge_pkg::HEIGHT_W'(row_reg) == height_use - 1'b1)
                      && (sedge_pkg::WIDTH_W'(col_reg) == width_use - 1'b1);
        ctl.center_col = col_reg - 1'b1;
        ctl.center_row = row_reg - 1'b1;
    end

    // Memory stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ctl_reg  <= ctl;
            s1_cur_reg  <= intensity;
            s1_addr_reg <= col_reg;
        end
    end

    sedge_linemem u_linemem (
        .aclk        (aclk),
        .rd_en       (s_accept),
        .rd_addr     (col_reg),
        .wr_en       (s1_valid_reg),
        .wr_addr     (s1_addr_reg),
        .wr_cur      (s1_cur_reg),
        .top_rd_data (top_data),
        .mid_rd_data (mid_data)
    );

    sedge_grad u_grad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .in_ctl    (s1_ctl_reg),
        .in_cur    (s1_cur_reg),
        .in_top    (top_data),
        .in_mid    (mid_data),
        .lim_sq    (lim_sq_reg),
        .done      (grad_done),
        .push      (grad_push),
        .push_data (grad_data)
    );

    // Pixels accepted but not yet through the gradient stages
    always_comb begin
        case ({s_accept, grad_done})
            2'b10:   inflight_next = inflight_reg + 1'b1;
            2'b01:   inflight_next = inflight_reg - 1'b1;
            default: inflight_next = inflight_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    sedge_ofifo u_ofifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (grad_push),
        .push_data (grad_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign m_tdata = {2'b00, out_data.center_row, out_data.center_col, out_data.level};
    assign m_tlast = out_data.last;

    // Checks
    `SEDGE_ASSERT_NXT(a_accept_to_mem, s_accept, s1_valid_reg,
        "accepted pixel did not reach the memory stage")
    `SEDGE_ASSERT_NXT(a_col_wrap, s_accept && col_wrap, col_reg == '0,
        "column counter did not wrap at the row end")
    `SEDGE_ASSERT_IMP(a_no_rw_clash, s_accept && s1_valid_reg, s1_addr_reg != col_reg,
        "line store read and write hit the same column")
    `SEDGE_ASSERT_IMP(a_no_overflow, grad_push && !(m_tvalid && m_tready),
        fifo_count < sedge_pkg::FIFO_CW'(sedge_pkg::FIFO_DEPTH),
        "result pushed into a full output queue")

endmodule
